/* rtl/cbm_pkg.sv */
// Shared codes, address constants and result type for the cartridge bank mapper.
package cbm_pkg;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int TARGET_W = 3;
    localparam int MADDR_W  = 22;

    localparam logic [OP_W-1:0] OP_CPU_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_CPU_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PPU_FETCH = 2'd2;

    localparam logic [TARGET_W-1:0] TGT_UNMAPPED = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_PRG_ROM  = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_WORK_RAM = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_PATTERN  = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_REGISTER = 3'd4;

    localparam logic [ADDR_W-1:0] ADDR_BANK_REG = 16'h5000;
    localparam logic [ADDR_W-1:0] ADDR_MODE_REG = 16'h5200;

    typedef struct packed {
        logic                pattern_low_bank;
        logic                vertical_mirroring;
        logic                mem_write;
        logic [MADDR_W-1:0]  mem_address;
        logic [TARGET_W-1:0] target;
    } result_t;

endpackage

/* rtl/cartridge_bank_mapper_ntlatch_unit.sv */
// Top level of the cartridge bank mapper with nametable-driven pattern bank latch.
//
// One access (CPU write, CPU read or PPU fetch) is taken per clock and its decode
// is registered in the result register; the rate is one beat per cycle, held back
// only when the result register is full and not taken. Decode and the bank, mode
// and latch updates are all combinational between the input handshake and the
// result register. large_work_ram moves the 0x6000 window to work RAM offset
// 128K; write it only while no beat is in flight.
module cartridge_bank_mapper_ntlatch_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,   // large_work_ram
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,       // address[15:0], write_data[23:16]
    input  logic [cbm_pkg::OP_W-1:0]     s_tuser,       // op[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,       // mem_address[21:0], mem_write[22],
                                                        // vertical_mirroring[23],
                                                        // pattern_low_bank[24], zero[31:25]
    output logic [cbm_pkg::TARGET_W-1:0] m_tuser        // target[2:0]
);
    import cbm_pkg::*;

    logic                large_wram_reg;
    logic [7:0]          bank_reg, bank_next;
    logic [2:0]          mode_reg, mode_next;
    logic                latch_reg, latch_next;
    logic                out_valid_reg;
    result_t             result_reg, result_next;

    logic                in_fire;
    logic [OP_W-1:0]     op;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   wdata;
    logic [13:0]         ppu_addr;
    logic                wram_win;
    logic [MADDR_W-1:0]  wram_addr;
    logic                bank_ram;
    logic [6:0]          bank_sel;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign op       = s_tuser;
    assign addr     = s_tdata[15:0];
    assign wdata    = s_tdata[23:16];
    assign ppu_addr = addr[13:0];
    assign wram_win = (addr[15:13] == 3'b011);
    assign wram_addr = {4'b0, large_wram_reg, 4'b0, addr[12:0]};
    assign bank_ram = bank_reg[7];

    always_comb begin
        bank_next   = bank_reg;
        mode_next   = mode_reg;
        latch_next  = latch_reg;
        result_next = '0;
        result_next.target = TGT_UNMAPPED;
        bank_sel = bank_reg[6:0];
        unique case (op)
            OP_CPU_WRITE: begin
                if (addr == ADDR_BANK_REG) begin
                    bank_next = wdata;
                    result_next.target = TGT_REGISTER;
                end else if (addr == ADDR_MODE_REG) begin
                    mode_next = wdata[2:0];
                    result_next.target = TGT_REGISTER;
                end else if (wram_win) begin
                    result_next.target      = TGT_WORK_RAM;
                    result_next.mem_address = wram_addr;
                    result_next.mem_write   = 1'b1;
                end
            end
            OP_CPU_READ: begin
                if (wram_win) begin
                    result_next.target      = TGT_WORK_RAM;
                    result_next.mem_address = wram_addr;
                end else if (addr[15]) begin
                    if (mode_reg[2]) begin
                        bank_sel = bank_ram ? {5'b0, bank_reg[1:0]} : bank_reg[6:0];
                        result_next.target      = bank_ram ? TGT_WORK_RAM : TGT_PRG_ROM;
                        result_next.mem_address = {bank_sel, addr[14:0]};
                    end else if (!addr[14]) begin
                        bank_sel = bank_ram ? {4'b0, bank_reg[2:0]} : bank_reg[6:0];
                        result_next.target      = bank_ram ? TGT_WORK_RAM : TGT_PRG_ROM;
                        result_next.mem_address = {1'b0, bank_sel, addr[13:0]};
                    end else begin
                        result_next.target      = TGT_PRG_ROM;
                        result_next.mem_address = {8'b0, addr[13:0]};
                    end
                end
            end
            OP_PPU_FETCH: begin
                if (mode_reg[1]) begin
                    if (ppu_addr[13:12] == 2'b10) begin
                        latch_next = ppu_addr[11];
                    end
                end else begin
                    latch_next = 1'b0;
                end
                if (!ppu_addr[13]) begin
                    result_next.target      = TGT_PATTERN;
                    result_next.mem_address = {9'b0, ppu_addr[12] | latch_next,
                                               ppu_addr[11:0]};
                end
            end
            default: begin
            end
        endcase
        result_next.vertical_mirroring = ~mode_next[0];
        result_next.pattern_low_bank   = latch_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            large_wram_reg <= 1'b0;
            bank_reg       <= '0;
            mode_reg       <= '0;
            latch_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                large_wram_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                bank_reg      <= bank_next;
                mode_reg      <= mode_next;
                latch_reg     <= latch_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.target;
    assign m_tdata  = {7'b0, result_reg.pattern_low_bank, result_reg.vertical_mirroring,
                       result_reg.mem_write, result_reg.mem_address};

`ifndef SYNTHESIS
    a_latch_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && op == OP_PPU_FETCH && !mode_reg[1]) |=> !latch_reg)
        else $error("pattern latch not cleared while latching is off");

    a_write_only_wram: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.mem_write) |-> (result_reg.target == TGT_WORK_RAM))
        else $error("memory write on a target other than work RAM");

    a_no_addr_unmapped: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (result_reg.target == TGT_UNMAPPED ||
                      result_reg.target == TGT_REGISTER)) |-> (result_reg.mem_address == '0))
        else $error("nonzero address on an unmapped or register beat");

    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_tvalid)
        else $error("accepted beat produced no result");

    a_bank_write_only: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && bank_reg != $past(bank_reg)) |->
            $past(in_fire && op == OP_CPU_WRITE && addr == ADDR_BANK_REG))
        else $error("bank register changed without a bank write");
`endif

endmodule
